### design/sace_pkg.sv
// Shared types and constants for the sprite column expander.
// No dependencies; every other design file refers to this package by scoped names.
package sace_pkg;

    // Configuration register indexes
    localparam logic [1:0] CfgIdxMode = 2'd0;
    localparam logic [1:0] CfgIdxFlip = 2'd1;

    // Extension modes
    localparam logic [2:0] ModeBasic    = 3'd0;
    localparam logic [2:0] ModeCodeBit  = 3'd1;
    localparam logic [2:0] ModeHeight   = 3'd2;
    localparam logic [2:0] ModeYOffset  = 3'd3;
    localparam logic [2:0] ModeYWrap    = 3'd4;

    // Position constants
    localparam logic [9:0]  FlipXBase = 10'd498;
    localparam logic [10:0] FlipYBase = 11'd240;
    localparam logic [10:0] YOffset   = 11'd6;
    localparam logic [10:0] YWrap     = 11'd256;

    // Queue between decode and emit
    localparam int QDepth = 2;
    localparam int QPtrW  = 1;
    localparam int QCntW  = 2;

    // One decoded sprite, ready to be split into tile rows
    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  color;
        logic        fx;
        logic        fy;
        logic [9:0]  x;
        logic [10:0] y;
        logic [2:0]  height;
    } t_desc;

endpackage

### design/sace_front.sv
// Front end: configuration registers, input acceptance and sprite decode.
// Depends on sace_pkg; pushes one t_desc per accepted entry into the queue.
module sace_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_code_low_byte,
    input  logic [7:0]           i_attribute_byte,
    input  logic [7:0]           i_y_byte,
    input  logic [7:0]           i_x_low_byte,
    input  logic [7:0]           i_extension_byte,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output sace_pkg::t_desc      o_q_desc
);

    logic [2:0] r_mode;
    logic       r_flip;

    logic [8:0]  px;
    logic [11:0] code;
    logic [2:0]  height;
    logic [10:0] py;
    logic        fx;
    logic        fy;
    logic        has_height;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sace_pkg::ModeBasic;
            r_flip <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sace_pkg::CfgIdxMode) begin
                r_mode <= i_cfg_data[2:0];
            end else if (i_cfg_index == sace_pkg::CfgIdxFlip) begin
                r_flip <= i_cfg_data[0];
            end
        end
    end

    // Stall while the queue has no room
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // Decode the entry according to the board variant
    always_comb begin
        has_height = (r_mode != sace_pkg::ModeBasic) && (r_mode != sace_pkg::ModeCodeBit);
        px     = {i_attribute_byte[4], i_x_low_byte};
        code   = {1'b0, i_attribute_byte[7:5], i_code_low_byte};
        height = 3'd0;
        py     = {3'b000, i_y_byte};
        fx     = 1'b0;
        fy     = 1'b0;
        if (r_mode != sace_pkg::ModeBasic) begin
            code[11] = i_extension_byte[0];
        end
        if (has_height) begin
            height = i_extension_byte[6:4];
            code   = code & ~{9'd0, height};
        end
        if (r_mode == sace_pkg::ModeYOffset) begin
            py = py + sace_pkg::YOffset;
            if (!i_extension_byte[1]) begin
                py = py - sace_pkg::YWrap;
            end
            fx = i_extension_byte[3];
            fy = i_extension_byte[2];
        end else if (r_mode == sace_pkg::ModeYWrap) begin
            if (i_extension_byte[1]) begin
                py = py - sace_pkg::YWrap;
            end
            fx = i_extension_byte[3];
            fy = i_extension_byte[2];
        end
        // Mirror the whole screen
        o_q_desc.x = {1'b0, px};
        if (r_flip) begin
            o_q_desc.x = sace_pkg::FlipXBase - {1'b0, px};
            py = sace_pkg::FlipYBase - {4'd0, height, 4'd0} - py;
            fx = !fx;
            fy = !fy;
        end
        o_q_desc.code   = code;
        o_q_desc.color  = i_attribute_byte[3:0];
        o_q_desc.fx     = fx;
        o_q_desc.fy     = fy;
        o_q_desc.y      = py;
        o_q_desc.height = height;
    end

endmodule

### design/sace_queue.sv
// Short register queue of decoded sprites between the front and back ends.
// Depends on sace_pkg for the descriptor type and queue sizing.
module sace_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sace_pkg::t_desc      i_desc,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output sace_pkg::t_desc      o_desc
);

    sace_pkg::t_desc             r_mem [sace_pkg::QDepth];
    logic [sace_pkg::QPtrW-1:0]  r_wr_ptr;
    logic [sace_pkg::QPtrW-1:0]  r_rd_ptr;
    logic [sace_pkg::QCntW-1:0]  r_count;

    assign o_full  = (r_count == sace_pkg::QCntW'(sace_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sace_pkg::QCntW'(sace_pkg::QDepth))
        else $error("queue occupancy above depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into full queue");
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("occupancy did not grow on push");
`endif

endmodule

### design/sace_back.sv
// Back end: expands one decoded sprite into its column of tile commands.
// Depends on sace_pkg; pops descriptors from sace_queue and owns the output register.
module sace_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  sace_pkg::t_desc      i_q_desc,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [11:0]          o_tile_code,
    output logic [3:0]           o_tile_color,
    output logic                 o_mirror_x,
    output logic                 o_mirror_y,
    output logic signed [9:0]    o_screen_x,
    output logic signed [10:0]   o_screen_y,
    output logic                 o_last_tile
);

    sace_pkg::t_desc r_desc;
    logic            r_busy;
    logic [2:0]      r_row;
    logic            r_out_valid;
    logic [11:0]     r_code;
    logic [3:0]      r_color;
    logic            r_fx;
    logic            r_fy;
    logic [9:0]      r_x;
    logic [10:0]     r_y;
    logic            r_last;

    logic            load;
    logic            row_last;
    logic [2:0]      y_step;

    assign load     = r_busy && (!r_out_valid || !i_out_stall);
    assign row_last = (r_row == r_desc.height);
    assign o_q_pop  = i_q_valid && (!r_busy || (load && row_last));

    // Rows go bottom-up when mirrored vertically
    assign y_step = r_desc.fy ? (r_desc.height - r_row) : r_row;

    // Track the sprite in progress and its row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (load && row_last) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_q_desc;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code  <= r_desc.code + {9'd0, r_row};
            r_color <= r_desc.color;
            r_fx    <= r_desc.fx;
            r_fy    <= r_desc.fy;
            r_x     <= r_desc.x;
            r_y     <= r_desc.y + {4'd0, y_step, 4'd0};
            r_last  <= row_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_code  = r_code;
    assign o_tile_color = r_color;
    assign o_mirror_x   = r_fx;
    assign o_mirror_y   = r_fy;
    assign o_screen_x   = $signed(r_x);
    assign o_screen_y   = $signed(r_y);
    assign o_last_tile  = r_last;

`ifndef SYNTHESIS
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_row <= r_desc.height)
        else $error("row index beyond sprite height");
    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_busy || (load && row_last)))
        else $error("new sprite taken while rows remain");
    a_last_ends_sprite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && row_last && !o_q_pop) |=> !r_busy)
        else $error("sprite still busy after its last row");
`endif

endmodule

### design/sprite_attribute_column_expander.sv
// Top level of the sprite column expander.
// Depends on sace_pkg, sace_front, sace_queue and sace_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one five-byte sprite entry.
//   Output channel (o_out_valid / i_out_stall) gives one tile command per row,
//   height+1 commands per entry, top row first (bottom row first when mirrored
//   vertically), o_last_tile on the final one. Configuration port (i_cfg_valid /
//   o_cfg_ready, i_cfg_index, i_cfg_data): index 0 is the extension mode, index 1
//   the screen flip; other indexes are ignored. o_cfg_ready is always high. Write only while the block is idle.
// Path: an accepted entry passes through the queue, the back end's descriptor
//   register and the output register before its first command shows.
// Throughput: the emit stage produces one tile row per cycle while the output is
//   not stalled; a two-entry queue lets decode run ahead.
// Reset (synchronous, active low) empties the queue and output register and
//   sets both configuration registers to zero.
// When the receiver stalls, the current command holds; the queue fills and
//   then o_in_stall rises until room opens.
module sprite_attribute_column_expander (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_code_low_byte,
    input  logic [7:0]           i_attribute_byte,
    input  logic [7:0]           i_y_byte,
    input  logic [7:0]           i_x_low_byte,
    input  logic [7:0]           i_extension_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [11:0]          o_tile_code,
    output logic [3:0]           o_tile_color,
    output logic                 o_mirror_x,
    output logic                 o_mirror_y,
    output logic signed [9:0]    o_screen_x,
    output logic signed [10:0]   o_screen_y,
    output logic                 o_last_tile
);

    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    sace_pkg::t_desc push_desc;
    sace_pkg::t_desc pop_desc;

    // Accept and decode entries
    sace_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_low_byte  (i_code_low_byte),
        .i_attribute_byte (i_attribute_byte),
        .i_y_byte         (i_y_byte),
        .i_x_low_byte     (i_x_low_byte),
        .i_extension_byte (i_extension_byte),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_desc         (push_desc)
    );

    // Buffer decoded sprites
    sace_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (pop_desc)
    );

    // Emit tile commands
    sace_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_desc     (pop_desc),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tile_code  (o_tile_code),
        .o_tile_color (o_tile_color),
        .o_mirror_x   (o_mirror_x),
        .o_mirror_y   (o_mirror_y),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_last_tile  (o_last_tile)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for sprite_attribute_column_expander.
// Depends on sace_pkg and the design; predicts every tile command of each sprite entry
// and checks the output stream in order under random idling and long output back-pressure.
`timescale 1ns / 1ps

module tb;

    // Register indexes the block ignores, and mode codes past the defined variants
    localparam logic [1:0] CfgIdxSpare2 = 2'd2;
    localparam logic [1:0] CfgIdxSpare3 = 2'd3;
    localparam logic [2:0] ModeSpare5   = 3'd5;
    localparam logic [2:0] ModeSpare7   = 3'd7;

    localparam int DrainCycles  = 8;
    localparam int ReportLimit  = 10;
    localparam int BlockItems   = 24;
    localparam int HoldOffLen   = 300;

    typedef struct packed {
        logic [7:0] code_lo;
        logic [7:0] attr;
        logic [7:0] y;
        logic [7:0] x_lo;
        logic [7:0] ext;
    } t_sprite_entry;

    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  color;
        logic        mx;
        logic        my;
        logic [9:0]  x;
        logic [10:0] y;
        logic        last;
    } t_tile_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_code_low_byte = '0;
    logic [7:0]  i_attribute_byte = '0;
    logic [7:0]  i_y_byte = '0;
    logic [7:0]  i_x_low_byte = '0;
    logic [7:0]  i_extension_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [11:0] o_tile_code;
    logic [3:0]  o_tile_color;
    logic        o_mirror_x;
    logic        o_mirror_y;
    logic signed [9:0]  o_screen_x;
    logic signed [10:0] o_screen_y;
    logic        o_last_tile;

    // Shadow of the configuration registers
    logic [2:0]  cur_mode = sace_pkg::ModeBasic;
    logic        cur_flip = 1'b0;

    t_tile_cmd   pending_tiles[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          sprites_sent = 0;
    int          tiles_seen = 0;
    int          reg_writes = 0;
    bit [7:0]    modes_used = '0;

    sprite_attribute_column_expander dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Expand one sprite entry into its column of tile commands
    function automatic void expand_sprite(input t_sprite_entry s);
        int          px, py, rows, ty;
        logic [11:0] base;
        logic        fx, fy;
        t_tile_cmd   t;
        px   = {s.attr[4], s.x_lo};
        py   = s.y;
        base = {1'b0, s.attr[7:5], s.code_lo};
        fx   = 1'b0;
        fy   = 1'b0;
        rows = 0;
        if (cur_mode != sace_pkg::ModeBasic) begin
            base[11] = s.ext[0];
            if (cur_mode >= sace_pkg::ModeHeight) begin
                rows = s.ext[6:4];
                base = base & ~12'(rows);
                if (cur_mode == sace_pkg::ModeYOffset) begin
                    py += int'(sace_pkg::YOffset);
                    if (!s.ext[1]) py -= int'(sace_pkg::YWrap);
                    fx = s.ext[3];
                    fy = s.ext[2];
                end else if (cur_mode == sace_pkg::ModeYWrap) begin
                    if (s.ext[1]) py -= int'(sace_pkg::YWrap);
                    fx = s.ext[3];
                    fy = s.ext[2];
                end
            end
        end
        if (cur_flip) begin
            px = int'(sace_pkg::FlipXBase) - px;
            py = int'(sace_pkg::FlipYBase) - 16 * rows - py;
            fx = ~fx;
            fy = ~fy;
        end
        for (int r = 0; r <= rows; r++) begin
            ty      = fy ? py + 16 * (rows - r) : py + 16 * r;
            t.code  = base + 12'(r);
            t.color = s.attr[3:0];
            t.mx    = fx;
            t.my    = fy;
            t.x     = px[9:0];
            t.y     = ty[10:0];
            t.last  = (r == rows);
            pending_tiles.push_back(t);
        end
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= ReportLimit)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Check each tile command and pick the next stall value
    initial begin : tile_checker
        t_tile_cmd want;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                tiles_seen++;
                if (pending_tiles.size() == 0) begin
                    note_mismatch("tile command with no sprite pending", 0, o_tile_code);
                end else begin
                    want = pending_tiles.pop_front();
                    if (o_tile_code !== want.code)
                        note_mismatch("tile_code", want.code, o_tile_code);
                    if (o_tile_color !== want.color)
                        note_mismatch("tile_color", want.color, o_tile_color);
                    if (o_mirror_x !== want.mx)
                        note_mismatch("mirror_x", want.mx, o_mirror_x);
                    if (o_mirror_y !== want.my)
                        note_mismatch("mirror_y", want.my, o_mirror_y);
                    if (o_screen_x !== want.x)
                        note_mismatch("screen_x", $signed(want.x), o_screen_x);
                    if (o_screen_y !== want.y)
                        note_mismatch("screen_y", $signed(want.y), o_screen_y);
                    if (o_last_tile !== want.last)
                        note_mismatch("last_tile", want.last, o_last_tile);
                end
            end
            // Hold off for the pressure stretch, else stall at random
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one sprite request and wait until it is taken
    task automatic send_sprite(input t_sprite_entry s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_code_low_byte  <= s.code_lo;
        i_attribute_byte <= s.attr;
        i_y_byte         <= s.y;
        i_x_low_byte     <= s.x_lo;
        i_extension_byte <= s.ext;
        do @(posedge i_clk); while (o_in_stall);
        expand_sprite(s);
        sprites_sent++;
    endtask

    task automatic send_random_sprite();
        t_sprite_entry s;
        s.code_lo = 8'($urandom_range(255));
        s.attr    = 8'($urandom_range(255));
        s.y       = 8'($urandom_range(255));
        s.x_lo    = 8'($urandom_range(255));
        s.ext     = 8'($urandom_range(255));
        send_sprite(s);
    endtask

    // Drop valid and let every pending tile command drain out
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_tiles.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Write one register; valid stays high until the caller releases it
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sace_pkg::CfgIdxMode: cur_mode = data[2:0];
            sace_pkg::CfgIdxFlip: cur_flip = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [2:0] mode, input logic flip);
        wait_for_idle();
        write_reg(sace_pkg::CfgIdxMode, {5'($urandom_range(31)), mode});
        write_reg(sace_pkg::CfgIdxFlip, {7'($urandom_range(127)), flip});
        i_cfg_valid <= 1'b0;
        modes_used[mode] = 1'b1;
    endtask

    // Field extremes and each mode's special rules
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // reset state: basic mode, unflipped
        send_sprite({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_sprite({8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        set_config(sace_pkg::ModeCodeBit, 1'b0);
        send_sprite({8'hff, 8'hff, 8'hff, 8'hff, 8'h01});
        send_sprite({8'h00, 8'h00, 8'h00, 8'h00, 8'hfe});
        // tallest column clears the low code bits; flipped screen
        set_config(sace_pkg::ModeHeight, 1'b1);
        send_sprite({8'hff, 8'hff, 8'hff, 8'hff, 8'h70});
        send_sprite({8'h00, 8'h10, 8'hff, 8'hff, 8'h00});
        set_config(sace_pkg::ModeYOffset, 1'b0);
        send_sprite({8'h12, 8'h34, 8'h00, 8'h56, 8'h0e});
        send_sprite({8'h12, 8'h34, 8'hff, 8'h56, 8'h71});
        set_config(sace_pkg::ModeYOffset, 1'b1);
        send_sprite({8'hab, 8'hcd, 8'h80, 8'hef, 8'h7c});
        send_sprite({8'h00, 8'h00, 8'h00, 8'h00, 8'h32});
        set_config(sace_pkg::ModeYWrap, 1'b0);
        send_sprite({8'h5a, 8'ha5, 8'h00, 8'h80, 8'h02});
        send_sprite({8'hff, 8'hff, 8'hff, 8'hff, 8'h7d});
        // rightmost X mirrors to the most negative position
        set_config(sace_pkg::ModeYWrap, 1'b1);
        send_sprite({8'h00, 8'h1f, 8'hff, 8'hff, 8'h7f});
        send_sprite({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // spare mode codes act like the height mode
        set_config(ModeSpare5, 1'b0);
        send_sprite({8'hff, 8'he0, 8'h10, 8'h20, 8'h7f});
        set_config(ModeSpare7, 1'b1);
        send_sprite({8'h3c, 8'hf0, 8'hf0, 8'h0f, 8'h5e});
    endtask

    // Writes to unused indexes must leave both registers alone
    task automatic test_ignored_index();
        set_config(sace_pkg::ModeYOffset, 1'b1);
        @(posedge i_clk);
        write_reg(CfgIdxSpare2, 8'h00);
        write_reg(CfgIdxSpare3, 8'hff);
        write_reg(CfgIdxSpare2, 8'hff);
        write_reg(CfgIdxSpare3, 8'h00);
        i_cfg_valid <= 1'b0;
        send_sprite({8'h81, 8'h7e, 8'h42, 8'hbd, 8'h3d});
        send_sprite({8'h7e, 8'h81, 8'hbd, 8'h42, 8'h4a});
    endtask

    // Random entries over several settings and idling patterns
    task automatic test_random_phases();
        int          idle_send[3] = '{18, 80, 0};
        int          idle_recv[3] = '{80, 18, 0};
        logic [2:0]  mode;
        for (int p = 0; p < 3; p++) begin
            for (int b = 0; b < 4; b++) begin
                case (b)
                    0: mode = sace_pkg::ModeBasic;
                    1: mode = sace_pkg::ModeYWrap;
                    2: mode = sace_pkg::ModeYOffset;
                    default: mode = 3'($urandom_range(7));
                endcase
                set_config(mode, 1'((p + b) % 2));
                if ($urandom_range(1)) begin
                    @(posedge i_clk);
                    write_reg(CfgIdxSpare3, 8'($urandom_range(255)));
                    i_cfg_valid <= 1'b0;
                end
                send_idle_pct = idle_send[p];
                recv_idle_pct = idle_recv[p];
                repeat (BlockItems) send_random_sprite();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
    endtask

    // Hold the output off long enough that the input must stall
    task automatic test_input_backpressure();
        set_config(sace_pkg::ModeHeight, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HoldOffLen;
        repeat (24) send_random_sprite();
        set_config(sace_pkg::ModeYOffset, 1'b1);
        recv_idle_pct = 30;
        hold_left     = HoldOffLen;
        repeat (24) send_random_sprite();
        recv_idle_pct = 0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_ignored_index();
        test_random_phases();
        test_input_backpressure();
        wait_for_idle();
        repeat (2 * DrainCycles) @(posedge i_clk);
        $display("Covered %0d sprite entries, %0d tile commands, %0d register writes,",
                 sprites_sent, tiles_seen, reg_writes);
        $display("mode codes used 0x%02h, both screen orientations, input back-pressure.",
                 modes_used);
        if (mismatches == 0 && pending_tiles.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
